### rtl/swrtt_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window RTT statistics package
// Field widths shared by the statistics block and its port checker.
// ----------------------------------------------------------------------------
package swrtt_pkg;

  // Width of one round-trip-time sample and of the mean and jitter results.
  localparam int SAMPLE_W = 24;

  // Width of the window fill field on the result channel.
  localparam int FILL_W = 4;

endpackage

### rtl/sliding_window_rtt_average_jitter.sv
// ----------------------------------------------------------------------------
// Sliding-window RTT average and jitter
// Keeps the last WIN_DEPTH samples in a ring memory with running totals of
// the samples and of the absolute differences between neighboring samples,
// and reports fill, truncated mean and truncated mean successive difference.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | input     | in_valid / in_ready   | in_rtt_sample
//  out_     | output    | out_valid / out_ready | out_window_fill, out_rtt_average,
//           |           |                       | out_rtt_jitter
//
// One beat is taken at a time. A full window reads the ring twice, for the oldest
// and the next-oldest sample, then the totals update and both dividers run.
// The result is registered in the output register, and the next beat is taken
// once that register has been loaded.
// Reset is synchronous and clears the counters and totals, not the ring.
// A stalled result holds the output register and keeps the next beat waiting.

module sliding_window_rtt_average_jitter
  import swrtt_pkg::*;
#(
  parameter int WIN_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_rtt_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FILL_W-1:0]   out_window_fill,
  output logic [SAMPLE_W-1:0] out_rtt_average,
  output logic [SAMPLE_W-1:0] out_rtt_jitter
);

  localparam int PTR_W  = $clog2(WIN_DEPTH);
  localparam int CNT_W  = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + PTR_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int FW     = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_OLD,
    S_RD_NEXT,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [SAMPLE_W-1:0]   newest_r;
  logic [SAMPLE_W-1:0]   old_r;
  logic [CNT_W-1:0]      fill_r;
  logic [PTR_W-1:0]      oldest_r;
  logic [PTR_W-1:0]      slot_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      dsum_r;
  logic [SUM_W-1:0]      quo_a_r;
  logic [SUM_W-1:0]      quo_b_r;
  logic [CNT_W-1:0]      rem_a_r;
  logic [CNT_W-1:0]      rem_b_r;
  logic [DCNT_W-1:0]     div_cnt_r;
  logic                  out_valid_r;
  logic [FILL_W-1:0]     out_fill_r;
  logic [SAMPLE_W-1:0]   out_avg_r;
  logic [SAMPLE_W-1:0]   out_jit_r;

  // Ring memory with one write port and one registered read port.
  logic [SAMPLE_W-1:0]   ring [WIN_DEPTH];
  logic [PTR_W-1:0]      rd_addr;
  logic [SAMPLE_W-1:0]   rd_data_r;
  logic                  wr_en;

  logic                  fill_full;
  logic [PTR_W-1:0]      next_ptr;
  logic [CNT_W:0]        slot_sum;
  logic [CNT_W:0]        slot_wrap;
  logic [PTR_W-1:0]      slot_nxt;
  logic [SAMPLE_W-1:0]   abs_evict;
  logic [SAMPLE_W-1:0]   abs_new;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SUM_W-1:0]      dsum_nxt;
  logic [CNT_W-1:0]      div_b;
  logic [CNT_W:0]        rem_sh_a;
  logic [CNT_W:0]        rem_sh_b;
  logic                  ge_a;
  logic                  ge_b;
  logic [FW-1:0]         fill_ext;
  logic                  out_load;

  // Pointer arithmetic and the slot that the new sample goes to.
  assign fill_full = (fill_r == CNT_W'(WIN_DEPTH));
  assign next_ptr  = (oldest_r == PTR_W'(WIN_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign slot_sum  = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(fill_r);
  assign slot_wrap = (slot_sum >= (CNT_W + 1)'(WIN_DEPTH)) ?
                     slot_sum - (CNT_W + 1)'(WIN_DEPTH) : slot_sum;
  assign slot_nxt  = fill_full ? oldest_r : PTR_W'(slot_wrap);

  // Address the oldest sample on acceptance, then the next-oldest one.
  assign rd_addr = (state_r == S_RD_OLD) ? next_ptr : oldest_r;
  assign wr_en   = (state_r == S_UPDATE);

  always_ff @(posedge clk) begin
    rd_data_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[slot_r] <= sample_r;
    end
  end

  // Differences removed on eviction and added for the new sample.
  assign abs_evict = (rd_data_r > old_r) ? rd_data_r - old_r : old_r - rd_data_r;
  assign abs_new   = (sample_r > newest_r) ? sample_r - newest_r : newest_r - sample_r;
  assign sum_nxt   = sum_r + SUM_W'(sample_r);
  assign dsum_nxt  = dsum_r + ((fill_r != '0) ? SUM_W'(abs_new) : '0);

  // One restoring step for each of the two dividers.
  assign div_b    = fill_r - 1'b1;
  assign rem_sh_a = {rem_a_r, quo_a_r[SUM_W-1]};
  assign rem_sh_b = {rem_b_r, quo_b_r[SUM_W-1]};
  assign ge_a     = (rem_sh_a >= {1'b0, fill_r});
  assign ge_b     = (rem_sh_b >= {1'b0, div_b});

  assign fill_ext = FW'(fill_r);

  // The output register loads once the previous result has left.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer, running totals and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      oldest_r    <= '0;
      sum_r       <= '0;
      dsum_r      <= '0;
      newest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_rtt_sample;
            slot_r   <= slot_nxt;
            state_r  <= fill_full ? S_RD_OLD : S_UPDATE;
          end
        end
        S_RD_OLD: begin
          old_r   <= rd_data_r;
          state_r <= S_RD_NEXT;
        end
        S_RD_NEXT: begin
          sum_r    <= sum_r - SUM_W'(old_r);
          dsum_r   <= dsum_r - SUM_W'(abs_evict);
          oldest_r <= next_ptr;
          fill_r   <= fill_r - 1'b1;
          state_r  <= S_UPDATE;
        end
        S_UPDATE: begin
          sum_r     <= sum_nxt;
          dsum_r    <= dsum_nxt;
          newest_r  <= sample_r;
          fill_r    <= fill_r + 1'b1;
          quo_a_r   <= sum_nxt;
          quo_b_r   <= dsum_nxt;
          rem_a_r   <= '0;
          rem_b_r   <= '0;
          div_cnt_r <= DCNT_W'(SUM_W - 1);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_a_r <= ge_a ? CNT_W'(rem_sh_a - {1'b0, fill_r}) : CNT_W'(rem_sh_a);
          rem_b_r <= ge_b ? CNT_W'(rem_sh_b - {1'b0, div_b}) : CNT_W'(rem_sh_b);
          quo_a_r <= {quo_a_r[SUM_W-2:0], ge_a};
          quo_b_r <= {quo_b_r[SUM_W-2:0], ge_b};
          if (div_cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_fill_r  <= fill_ext[FILL_W-1:0];
            out_avg_r   <= quo_a_r[SAMPLE_W-1:0];
            out_jit_r   <= (fill_r < CNT_W'(2)) ? '0 : quo_b_r[SAMPLE_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_window_fill = out_fill_r;
  assign out_rtt_average = out_avg_r;
  assign out_rtt_jitter  = out_jit_r;

endmodule

### rtl/swrtt_checker.sv
// ----------------------------------------------------------------------------
// Sliding-window RTT port checker
// Watches the ports of the statistics block and flags illegal behavior.
// ----------------------------------------------------------------------------
module swrtt_checker
  import swrtt_pkg::*;
#(
  parameter int WIN_DEPTH = 10
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [FILL_W-1:0]   out_window_fill,
  input logic [SAMPLE_W-1:0] out_rtt_average,
  input logic [SAMPLE_W-1:0] out_rtt_jitter
);

  localparam bit FILL_FITS = (WIN_DEPTH < 16);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_fill) &&
    $stable(out_rtt_average) && $stable(out_rtt_jitter))
    else $error("result beat changed while stalled");

  // The block works on one beat at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // The reported fill lies between one and the window depth.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    FILL_FITS && out_valid |->
    out_window_fill != '0 && out_window_fill <= FILL_W'(WIN_DEPTH))
    else $error("window fill out of range");

  // A single sample has no jitter.
  a_jit_one: assert property (@(posedge clk) disable iff (!rst_n)
    FILL_FITS && out_valid && out_window_fill == FILL_W'(1) |-> out_rtt_jitter == '0)
    else $error("jitter reported for a single sample");

endmodule

bind sliding_window_rtt_average_jitter swrtt_checker #(
  .WIN_DEPTH(WIN_DEPTH)
) u_swrtt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_window_fill (out_window_fill),
  .out_rtt_average (out_rtt_average),
  .out_rtt_jitter  (out_rtt_jitter)
);

### tb/tb_sliding_window_rtt_average_jitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window RTT average and jitter testbench
// Drives round-trip-time samples into the block and checks every result beat
// against a local model of the window. The model tracks the ring, the fill,
// the running sample total and the running total of neighbor differences.
// Directed tests cover the first sample, the field extremes and window
// eviction. A long output stall fills the block up. Random traffic then runs
// with varied value shapes and with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_sliding_window_rtt_average_jitter
  import swrtt_pkg::*;
();

  localparam int WINDOW        = 10;
  localparam int RANDOM_ITEMS  = 1520;
  localparam int MAX_IDLE      = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int EXP_DEPTH     = 64;
  localparam logic [SAMPLE_W-1:0] RTT_MAX = {SAMPLE_W{1'b1}};

  // Shapes of random RTT values.
  typedef enum int {
    SHAPE_FULL,
    SHAPE_LOW,
    SHAPE_HIGH,
    SHAPE_REPEAT,
    SHAPE_TYPICAL,
    SHAPE_EDGE
  } rtt_shape_t;

  typedef struct packed {
    logic [FILL_W-1:0]   fill;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] jitter;
  } rtt_stats_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_rtt_sample;
  logic                out_valid;
  logic                out_ready;
  logic [FILL_W-1:0]   out_window_fill;
  logic [SAMPLE_W-1:0] out_rtt_average;
  logic [SAMPLE_W-1:0] out_rtt_jitter;

  // Window model state.
  logic [SAMPLE_W-1:0] win_ring [WINDOW];
  int unsigned         win_fill;
  int unsigned         win_oldest;
  longint unsigned     win_sum;
  longint unsigned     win_diff_sum;
  logic [SAMPLE_W-1:0] win_newest;

  // Expected stats in order; the sender writes, the checker reads.
  rtt_stats_t          expected_stats [EXP_DEPTH];
  int unsigned         exp_wr_count;
  int unsigned         exp_rd_count;
  logic [SAMPLE_W-1:0] last_rtt;
  bit                  sender_idle_on;
  bit                  receiver_idle_on;
  int                  hold_requests;
  int                  samples_sent;
  int                  results_checked;
  int                  error_count;
  int                  quiet_cycles;

  sliding_window_rtt_average_jitter #(
    .WIN_DEPTH(WINDOW)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rtt_sample  (in_rtt_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_fill(out_window_fill),
    .out_rtt_average(out_rtt_average),
    .out_rtt_jitter (out_rtt_jitter)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned abs_gap(input logic [SAMPLE_W-1:0] a,
                                              input logic [SAMPLE_W-1:0] b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  // Apply one sample to the window model and return the stats it yields.
  function automatic rtt_stats_t update_window_stats(input logic [SAMPLE_W-1:0] rtt);
    int unsigned         slot;
    logic [SAMPLE_W-1:0] oldest;
    logic [SAMPLE_W-1:0] next_oldest;
    rtt_stats_t          stats;
    // A full window drops its oldest sample and that sample's difference.
    if (win_fill == WINDOW) begin
      oldest       = win_ring[win_oldest];
      next_oldest  = win_ring[(win_oldest + 1) % WINDOW];
      win_sum      -= oldest;
      win_diff_sum -= abs_gap(next_oldest, oldest);
      slot         = win_oldest;
      win_oldest   = (win_oldest + 1) % WINDOW;
      win_fill--;
    end else begin
      slot = (win_oldest + win_fill) % WINDOW;
    end
    if (win_fill >= 1) begin
      win_diff_sum += abs_gap(rtt, win_newest);
    end
    win_ring[slot] = rtt;
    win_sum       += rtt;
    win_newest     = rtt;
    win_fill++;
    stats.fill    = win_fill[FILL_W-1:0];
    stats.average = SAMPLE_W'(win_sum / win_fill);
    stats.jitter  = (win_fill >= 2) ? SAMPLE_W'(win_diff_sum / (win_fill - 1)) : '0;
    return stats;
  endfunction

  function automatic int draw_idle(input bit enabled);
    return enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
  endfunction

  // Offer one sample beat and record its expected stats once it is taken.
  task automatic send_rtt(input logic [SAMPLE_W-1:0] rtt);
    int gap;
    gap = draw_idle(sender_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rtt_sample <= rtt;
    do @(posedge clk); while (!in_ready);
    expected_stats[exp_wr_count % EXP_DEPTH] = update_window_stats(rtt);
    exp_wr_count++;
    last_rtt = rtt;
    samples_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_rtt();
    rtt_shape_t shape;
    shape = rtt_shape_t'($urandom_range(SHAPE_FULL, SHAPE_EDGE));
    case (shape)
      SHAPE_FULL:    return SAMPLE_W'($urandom);
      SHAPE_LOW:     return SAMPLE_W'($urandom_range(0, 1000));
      SHAPE_HIGH:    return RTT_MAX - SAMPLE_W'($urandom_range(0, 1000));
      SHAPE_REPEAT:  return last_rtt;
      SHAPE_TYPICAL: return SAMPLE_W'($urandom_range(5000, 200000));
      default:       return $urandom_range(0, 1) ? RTT_MAX : '0;
    endcase
  endfunction

  // First sample, then alternating extremes to reach maximum jitter.
  task automatic test_first_and_extremes();
    send_rtt('0);
    for (int i = 0; i < 11; i++) begin
      send_rtt((i % 2 == 0) ? RTT_MAX : '0);
    end
  endtask

  // Eviction with the window full: steps, a constant run and single bits.
  task automatic test_window_eviction();
    send_rtt(24'h000001);
    send_rtt(24'h800000);
    send_rtt(24'h7FFFFF);
    for (int i = 0; i < 6; i++) begin
      send_rtt(24'h123456);
    end
    send_rtt(24'h555555);
    send_rtt(24'hAAAAAA);
    send_rtt(RTT_MAX);
  endtask

  // The receiver stops for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 15; i++) begin
      send_rtt(random_rtt());
    end
  endtask

  // Random samples in phases with different idle patterns.
  task automatic test_random_rtt();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        sender_idle_on   = (i / 100) % 4 != 1 && (i / 100) % 4 != 3;
        receiver_idle_on = (i / 100) % 4 < 2;
      end
      send_rtt(random_rtt());
    end
  endtask

  // Receiver: random stalls per beat, plus a long hold-off on request.
  initial begin
    int stall;
    int holds_served;
    out_ready    = 1'b0;
    holds_served = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_requests != holds_served) begin
        stall = HOLD_CYCLES;
        holds_served++;
      end else begin
        stall = draw_idle(receiver_idle_on);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    rtt_stats_t exp_stats;
    if (rst_n && out_valid && out_ready) begin
      if (exp_rd_count == exp_wr_count) begin
        $error("result beat with no expected stats: fill %0d avg %0d jitter %0d",
               out_window_fill, out_rtt_average, out_rtt_jitter);
        error_count++;
      end else begin
        exp_stats = expected_stats[exp_rd_count % EXP_DEPTH];
        exp_rd_count++;
        results_checked++;
        if (out_window_fill !== exp_stats.fill) begin
          $error("window_fill: expected %0d, actual %0d", exp_stats.fill, out_window_fill);
          error_count++;
        end
        if (out_rtt_average !== exp_stats.average) begin
          $error("rtt_average: expected %0d, actual %0d", exp_stats.average,
                 out_rtt_average);
          error_count++;
        end
        if (out_rtt_jitter !== exp_stats.jitter) begin
          $error("rtt_jitter: expected %0d, actual %0d", exp_stats.jitter, out_rtt_jitter);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog expired with %0d results outstanding",
                 exp_wr_count - exp_rd_count);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_rtt_sample    = '0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    samples_sent     = 0;
    last_rtt         = '0;
    win_fill         = 0;
    win_oldest       = 0;
    win_sum          = 0;
    win_diff_sum     = 0;
    win_newest       = '0;
    foreach (win_ring[i]) win_ring[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_and_extremes();
    test_window_eviction();
    test_output_backpressure();
    test_random_rtt();
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for any stray beat.
    while (exp_wr_count != exp_rd_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d RTT samples sent, %0d results checked, %0d mismatches",
             samples_sent, results_checked, error_count);
    $display("tb: covered first sample, field extremes, window eviction, long output stall");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
